// ----- hw/rtl/wrhp_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wrhp_pkg
// Shared types and constants of the RIFF/WAVE header parser.
// ----------------------------------------------------------------------------
package wrhp_pkg;

  // Four-byte tags as gathered little-endian
  localparam logic [31:0] TagRiff = 32'h4646_4952;
  localparam logic [31:0] TagWave = 32'h4556_4157;
  localparam logic [31:0] TagFmt  = 32'h2074_6D66;
  localparam logic [31:0] TagData = 32'h6174_6164;

  localparam logic [31:0] FmtMin   = 32'd16;
  localparam logic [32:0] RiffBase = 33'd8;
  localparam logic [32:0] PosMax   = 33'h1_FFFF_FFFF;

  localparam int unsigned OutDataW = 128;

  typedef enum logic [1:0] {
    KIND_DESC = 2'd0,
    KIND_DATA = 2'd1,
    KIND_ERR  = 2'd2
  } kind_e;

  typedef enum logic [2:0] {
    ERR_NOT_RIFF   = 3'd0,
    ERR_HDR_TRUNC  = 3'd1,
    ERR_NOT_WAVE   = 3'd2,
    ERR_FMT_SMALL  = 3'd3,
    ERR_DATA_FIRST = 3'd4,
    ERR_NO_FMT     = 3'd5,
    ERR_NO_DATA    = 3'd6,
    ERR_DATA_TRUNC = 3'd7
  } err_e;

  typedef enum logic [10:0] {
    PH_RIFF      = 11'b000_0000_0001,
    PH_RSIZE     = 11'b000_0000_0010,
    PH_WAVE      = 11'b000_0000_0100,
    PH_CID       = 11'b000_0000_1000,
    PH_SZ_FMT    = 11'b000_0001_0000,
    PH_SZ_DATA   = 11'b000_0010_0000,
    PH_SZ_OTHER  = 11'b000_0100_0000,
    PH_FMT       = 11'b000_1000_0000,
    PH_FMT_EXTRA = 11'b001_0000_0000,
    PH_SKIP      = 11'b010_0000_0000,
    PH_DATA      = 11'b100_0000_0000
  } phase_e;

  typedef struct packed {
    kind_e       kind;
    logic [1:0]  format_code;
    logic [15:0] channel_count;
    logic [31:0] rate_hz;
    logic [15:0] bits_per_sample;
    logic [15:0] audio_format;
    logic [31:0] data_size;
    logic [7:0]  data_byte;
    err_e        error_code;
    logic        last;
  } res_t;

endpackage

// ----- hw/rtl/wrhp_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wrhp_core
// Parser state and per-byte step logic; produces at most one result per item.
// ----------------------------------------------------------------------------
module wrhp_core import wrhp_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       step_i,
  input  logic       action_i,
  input  logic [7:0] byte_i,
  output logic       res_valid_o,
  output res_t       res_o
);

  phase_e      phase_q, phase_d;
  logic [32:0] pos_q, pos_d;
  logic [32:0] riff_end_q, riff_end_d;
  logic [23:0] shift_q, shift_d;
  logic [1:0]  count_q, count_d;
  logic [3:0]  fmt_idx_q, fmt_idx_d;
  logic [31:0] rem_q, rem_d;
  logic [15:0] fmt_tag_q, fmt_tag_d;
  logic [15:0] fmt_ch_q, fmt_ch_d;
  logic [31:0] fmt_rate_q, fmt_rate_d;
  logic [15:0] fmt_bits_q, fmt_bits_d;
  logic        fmt_seen_q, fmt_seen_d;
  logic        finished_q, finished_d;

  logic        done;
  logic [31:0] word;
  logic [32:0] pos_inc;
  logic        at_end;
  logic [23:0] shift_gather;
  err_e        walk_err;

  assign done     = (count_q == 2'd3);
  assign word     = {byte_i, shift_q};
  assign pos_inc  = (pos_q == PosMax) ? pos_q : pos_q + 33'd1;
  assign at_end   = (pos_inc >= riff_end_q);
  assign walk_err = fmt_seen_q ? ERR_NO_DATA : ERR_NO_FMT;

  always_comb begin
    shift_gather = shift_q;
    case (count_q)
      2'd0:    shift_gather[7:0]   = byte_i;
      2'd1:    shift_gather[15:8]  = byte_i;
      2'd2:    shift_gather[23:16] = byte_i;
      default: shift_gather        = shift_q;
    endcase
  end

  always_comb begin
    phase_d     = phase_q;
    pos_d       = pos_q;
    riff_end_d  = riff_end_q;
    shift_d     = shift_q;
    count_d     = count_q;
    fmt_idx_d   = fmt_idx_q;
    rem_d       = rem_q;
    fmt_tag_d   = fmt_tag_q;
    fmt_ch_d    = fmt_ch_q;
    fmt_rate_d  = fmt_rate_q;
    fmt_bits_d  = fmt_bits_q;
    fmt_seen_d  = fmt_seen_q;
    finished_d  = finished_q;
    res_valid_o = 1'b0;
    res_o       = '0;

    if (step_i && action_i) begin
      // end of file: report unless already finished, then back to reset state
      if (!finished_q) begin
        res_valid_o  = 1'b1;
        res_o.kind   = KIND_ERR;
        res_o.last   = 1'b1;
        case (phase_q)
          PH_RIFF:  res_o.error_code = ERR_NOT_RIFF;
          PH_RSIZE: res_o.error_code = ERR_HDR_TRUNC;
          PH_WAVE:  res_o.error_code = ERR_NOT_WAVE;
          PH_DATA:  res_o.error_code = ERR_DATA_TRUNC;
          default:  res_o.error_code = walk_err;
        endcase
      end
      phase_d    = PH_RIFF;
      pos_d      = '0;
      count_d    = '0;
      fmt_seen_d = 1'b0;
      finished_d = 1'b0;
    end else if (step_i && !finished_q) begin
      pos_d   = pos_inc;
      shift_d = shift_gather;
      case (phase_q)
        PH_RIFF, PH_RSIZE, PH_WAVE, PH_CID, PH_SZ_FMT, PH_SZ_DATA, PH_SZ_OTHER:
          count_d = count_q + 2'd1;
        default: count_d = count_q;
      endcase

      case (phase_q)
        PH_RIFF: begin
          if (done) begin
            if (word != TagRiff) begin
              res_valid_o      = 1'b1;
              res_o.kind       = KIND_ERR;
              res_o.error_code = ERR_NOT_RIFF;
              res_o.last       = 1'b1;
              finished_d       = 1'b1;
            end else begin
              phase_d = PH_RSIZE;
            end
          end
        end
        PH_RSIZE: begin
          if (done) begin
            riff_end_d = RiffBase + {1'b0, word};
            phase_d    = PH_WAVE;
          end
        end
        PH_WAVE: begin
          if (done) begin
            if (word != TagWave) begin
              res_valid_o      = 1'b1;
              res_o.kind       = KIND_ERR;
              res_o.error_code = ERR_NOT_WAVE;
              res_o.last       = 1'b1;
              finished_d       = 1'b1;
            end else begin
              phase_d = PH_CID;
              if (at_end) begin
                res_valid_o      = 1'b1;
                res_o.kind       = KIND_ERR;
                res_o.error_code = walk_err;
                res_o.last       = 1'b1;
                finished_d       = 1'b1;
              end
            end
          end
        end
        PH_CID: begin
          if (done) begin
            if (word == TagFmt) begin
              phase_d = PH_SZ_FMT;
            end else if (word == TagData) begin
              phase_d = PH_SZ_DATA;
            end else begin
              phase_d = PH_SZ_OTHER;
            end
          end
        end
        PH_SZ_FMT: begin
          if (done) begin
            if (word < FmtMin) begin
              res_valid_o      = 1'b1;
              res_o.kind       = KIND_ERR;
              res_o.error_code = ERR_FMT_SMALL;
              res_o.last       = 1'b1;
              finished_d       = 1'b1;
            end else begin
              rem_d     = word - FmtMin;
              fmt_idx_d = '0;
              phase_d   = PH_FMT;
            end
          end
        end
        PH_FMT: begin
          case (fmt_idx_q)
            4'd0:    fmt_tag_d[7:0]    = byte_i;
            4'd1:    fmt_tag_d[15:8]   = byte_i;
            4'd2:    fmt_ch_d[7:0]     = byte_i;
            4'd3:    fmt_ch_d[15:8]    = byte_i;
            4'd4:    fmt_rate_d[7:0]   = byte_i;
            4'd5:    fmt_rate_d[15:8]  = byte_i;
            4'd6:    fmt_rate_d[23:16] = byte_i;
            4'd7:    fmt_rate_d[31:24] = byte_i;
            4'd14:   fmt_bits_d[7:0]   = byte_i;
            4'd15:   fmt_bits_d[15:8]  = byte_i;
            default: fmt_tag_d         = fmt_tag_q;
          endcase
          fmt_idx_d = fmt_idx_q + 4'd1;
          if (fmt_idx_q == 4'd15) begin
            fmt_seen_d = 1'b1;
            if (rem_q == '0) begin
              phase_d = PH_CID;
              count_d = '0;
              if (at_end) begin
                res_valid_o      = 1'b1;
                res_o.kind       = KIND_ERR;
                res_o.error_code = ERR_NO_DATA;
                res_o.last       = 1'b1;
                finished_d       = 1'b1;
              end
            end else begin
              phase_d = PH_FMT_EXTRA;
            end
          end
        end
        PH_FMT_EXTRA, PH_SKIP: begin
          if (rem_q != '0) begin
            rem_d = rem_q - 32'd1;
          end
          if (rem_q <= 32'd1) begin
            phase_d = PH_CID;
            count_d = '0;
            if (at_end) begin
              res_valid_o      = 1'b1;
              res_o.kind       = KIND_ERR;
              res_o.error_code = walk_err;
              res_o.last       = 1'b1;
              finished_d       = 1'b1;
            end
          end
        end
        PH_SZ_OTHER: begin
          if (done) begin
            rem_d = word;
            if (word == '0) begin
              phase_d = PH_CID;
              if (at_end) begin
                res_valid_o      = 1'b1;
                res_o.kind       = KIND_ERR;
                res_o.error_code = walk_err;
                res_o.last       = 1'b1;
                finished_d       = 1'b1;
              end
            end else begin
              phase_d = PH_SKIP;
            end
          end
        end
        PH_SZ_DATA: begin
          if (done) begin
            res_valid_o = 1'b1;
            if (!fmt_seen_q) begin
              res_o.kind       = KIND_ERR;
              res_o.error_code = ERR_DATA_FIRST;
              res_o.last       = 1'b1;
              finished_d       = 1'b1;
            end else begin
              res_o.kind            = KIND_DESC;
              res_o.format_code     = {fmt_ch_q != 16'd1, fmt_bits_q != 16'd8};
              res_o.channel_count   = fmt_ch_q;
              res_o.rate_hz         = fmt_rate_q;
              res_o.bits_per_sample = fmt_bits_q;
              res_o.audio_format    = fmt_tag_q;
              res_o.data_size       = word;
              rem_d                 = word;
              if (word == '0) begin
                res_o.last = 1'b1;
                finished_d = 1'b1;
              end else begin
                phase_d = PH_DATA;
              end
            end
          end
        end
        PH_DATA: begin
          res_valid_o     = 1'b1;
          res_o.kind      = KIND_DATA;
          res_o.data_byte = byte_i;
          if (rem_q != '0) begin
            rem_d = rem_q - 32'd1;
          end
          if (rem_q <= 32'd1) begin
            res_o.last = 1'b1;
            finished_d = 1'b1;
          end
        end
        default: phase_d = phase_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= PH_RIFF;
      pos_q      <= '0;
      count_q    <= '0;
      fmt_seen_q <= 1'b0;
      finished_q <= 1'b0;
    end else begin
      phase_q    <= phase_d;
      pos_q      <= pos_d;
      count_q    <= count_d;
      fmt_seen_q <= fmt_seen_d;
      finished_q <= finished_d;
    end
  end

  always_ff @(posedge clk_i) begin
    riff_end_q <= riff_end_d;
    shift_q    <= shift_d;
    fmt_idx_q  <= fmt_idx_d;
    rem_q      <= rem_d;
    fmt_tag_q  <= fmt_tag_d;
    fmt_ch_q   <= fmt_ch_d;
    fmt_rate_q <= fmt_rate_d;
    fmt_bits_q <= fmt_bits_d;
  end

`ifndef SYNTHESIS
  a_quiet_after_final: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i && !action_i && finished_q |-> !res_valid_o)
    else $error("result after final item");
  a_err_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && res_o.kind == KIND_ERR |-> res_o.last)
    else $error("error result not marked last");
  a_eof_resets: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i && action_i |=> phase_q == PH_RIFF && !finished_q && !fmt_seen_q)
    else $error("end of file did not reset parser");
  a_desc_needs_fmt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && res_o.kind == KIND_DESC |-> fmt_seen_q && phase_q == PH_SZ_DATA)
    else $error("descriptor without fmt chunk");
`endif

endmodule

// ----- hw/rtl/wav_riff_header_parser_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wav_riff_header_parser_top
// Byte-stream RIFF/WAVE header parser with a registered result stream.
// ----------------------------------------------------------------------------
// Input: one item per file byte on s_axis; tuser high marks end of file and
// returns the parser to its start state for the next file (tdata ignored).
// Output: zero or one item per input item on m_axis. tuser carries the kind
// (format descriptor, data byte, error); tlast marks the final item of a file.
// Latency: a result appears on m_axis the cycle after its input is accepted.
// Throughput: one byte per clock while results are taken; every step is one
// pass through the parser state update into the one-deep output register.
// Stall: s_axis_tready stays high while the output register is empty or
// being taken in the same cycle; a stalled result holds until taken.
// Reset: parser waits for the RIFF tag, output register is empty.
// ----------------------------------------------------------------------------
module wav_riff_header_parser_top import wrhp_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_axis_tvalid_i,
  output logic                s_axis_tready_o,
  input  logic [7:0]          s_axis_tdata_i,   // in_byte
  input  logic                s_axis_tuser_i,   // action
  output logic                m_axis_tvalid_o,
  input  logic                m_axis_tready_i,
  // format_code, channel_count, rate_hz, bits_per_sample, audio_format,
  // data_size, data_byte, error_code, zero fill
  output logic [OutDataW-1:0] m_axis_tdata_o,
  output logic [1:0]          m_axis_tuser_o,   // kind
  output logic                m_axis_tlast_o
);

  logic accept;
  logic core_valid;
  res_t core_res;
  logic out_vld_q, out_vld_d;
  res_t out_q;

  assign s_axis_tready_o = !out_vld_q || m_axis_tready_i;
  assign accept          = s_axis_tvalid_i && s_axis_tready_o;

  wrhp_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_i      (accept),
    .action_i    (s_axis_tuser_i),
    .byte_i      (s_axis_tdata_i),
    .res_valid_o (core_valid),
    .res_o       (core_res)
  );

  always_comb begin
    out_vld_d = out_vld_q;
    if (accept) begin
      out_vld_d = core_valid;
    end else if (m_axis_tready_i) begin
      out_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else begin
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept && core_valid) begin
      out_q <= core_res;
    end
  end

  assign m_axis_tvalid_o = out_vld_q;
  assign m_axis_tuser_o  = out_q.kind;
  assign m_axis_tlast_o  = out_q.last;
  assign m_axis_tdata_o  = {3'b000, out_q.error_code, out_q.data_byte, out_q.data_size,
                            out_q.audio_format, out_q.bits_per_sample, out_q.rate_hz,
                            out_q.channel_count, out_q.format_code};

endmodule
